// ===== design/glyph_page_blitter_core_macros.svh =====
// ---------------------------------------------------------------------------
// Glyph page blitter assertion macros
// Shared concurrent assertion forms for the blitter checker.
// ---------------------------------------------------------------------------
`ifndef GLYPH_PAGE_BLITTER_CORE_MACROS_SVH
`define GLYPH_PAGE_BLITTER_CORE_MACROS_SVH

// Check a property outside reset
`define GPB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that also covers reset cycles
`define GPB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gpb_pkg.sv =====
// ---------------------------------------------------------------------------
// Glyph page blitter package
// Configuration layout, register indexes, queue and write types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpb_pkg;

  // Font addresses are carried at the widest font memory size
  localparam int FA_W    = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Configuration register indexes
  localparam logic [2:0] CFG_DISPLAY_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_DISPLAY_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_FIRST_CHAR     = 3'd2;
  localparam logic [2:0] CFG_LAST_CHAR      = 3'd3;
  localparam logic [2:0] CFG_GLYPH_COLUMNS  = 3'd4;
  localparam logic [2:0] CFG_GLYPH_PAGES    = 3'd5;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic [7:0] display_width;
    logic [6:0] display_height;
    logic [7:0] first_char;
    logic [7:0] last_char;
    logic [4:0] glyph_columns;
    logic [2:0] glyph_pages;
  } cfg_t;

  // One queued command: a font load or a classified draw
  typedef struct packed {
    logic            is_load;
    logic            opens;
    logic [6:0]      start_x;
    logic [5:0]      start_y;
    logic            in_range;
    logic            color;
    logic [FA_W-1:0] addr;
    logic [7:0]      data;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One framebuffer write
  typedef struct packed {
    logic [9:0] fb_addr;
    logic [7:0] fb_data;
    logic       last;
  } wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WREAD,
    BK_WCHK,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== design/gpb_front.sv =====
// ---------------------------------------------------------------------------
// Glyph page blitter front end
// Accepts items, tracks dropped strings and works out glyph record bases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  gpb_pkg::cfg_t    cfg,
  input  logic [7:0]       stride,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [11:0]      in_font_addr,
  input  logic [7:0]       in_font_byte,
  input  logic [7:0]       in_char_code,
  input  logic [6:0]       in_start_x,
  input  logic [5:0]       in_start_y,
  input  logic             in_opens_string,
  input  logic             in_color,
  input  gpb_pkg::q_stat_t q_stat,
  output logic             q_push,
  output gpb_pkg::cmd_t    q_cmd
);

  logic        dropped_r;
  logic        dropped_nxt;
  logic        accept;
  logic        is_draw;
  logic        start_off;
  logic        dropped_eff;
  logic        in_range;
  logic [7:0]  offset;
  logic [15:0] base;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign is_draw  = (in_req_type == gpb_pkg::REQ_DRAW);

  // Classify the string start against the display
  assign start_off   = ({1'b0, in_start_x} >= cfg.display_width) ||
                       ({1'b0, in_start_y} >= cfg.display_height);
  assign dropped_eff = in_opens_string ? start_off : dropped_r;

  // Locate the glyph record
  assign in_range = (in_char_code >= cfg.first_char) && (in_char_code <= cfg.last_char);
  assign offset   = in_char_code - cfg.first_char;
  assign base     = in_range ? (16'(offset) * 16'(stride)) : 16'd0;

  // Hold the dropped flag until the next opening item
  always_comb begin
    dropped_nxt = dropped_r;
    if (accept && is_draw && in_opens_string) begin
      dropped_nxt = start_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropped_r <= 1'b0;
    end else begin
      dropped_r <= dropped_nxt;
    end
  end

  // Queue loads and live draws, discard draws of a dropped string
  assign q_push = accept && (!is_draw || !dropped_eff);

  always_comb begin
    q_cmd          = '0;
    q_cmd.is_load  = !is_draw;
    q_cmd.opens    = in_opens_string;
    q_cmd.start_x  = in_start_x;
    q_cmd.start_y  = in_start_y;
    q_cmd.in_range = in_range;
    q_cmd.color    = in_color;
    q_cmd.data     = in_font_byte;
    if (is_draw) begin
      q_cmd.addr = gpb_pkg::FA_W'(base);
    end else begin
      q_cmd.addr = gpb_pkg::FA_W'(in_font_addr);
    end
  end

endmodule

// ===== design/gpb_queue.sv =====
// ---------------------------------------------------------------------------
// Glyph page blitter command queue
// Short first-in first-out store between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gpb_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output gpb_pkg::cmd_t    head_cmd,
  output gpb_pkg::q_stat_t stat
);

  gpb_pkg::cmd_t                  slot_r [gpb_pkg::QDEPTH];
  logic [gpb_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [gpb_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [gpb_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [gpb_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [gpb_pkg::QCNT_W-1:0]     count_r;
  logic [gpb_pkg::QCNT_W-1:0]     count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign stat.full  = (count_r == gpb_pkg::QCNT_W'(gpb_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/gpb_back.sv =====
// ---------------------------------------------------------------------------
// Glyph page blitter back end
// Owns the font memory and cursor, walks glyph records into page writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpb_back #(
  parameter int FONT_BYTES  = 4096,
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_PAGES   = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gpb_pkg::cfg_t    cfg,
  input  gpb_pkg::q_stat_t q_stat,
  input  gpb_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [9:0]       out_fb_addr,
  output logic [7:0]       out_fb_data,
  output logic             out_last
);

  localparam int AW = $clog2(FONT_BYTES);
  localparam logic [7:0] MAX_COLS_B  = 8'(MAX_COLUMNS);
  localparam logic [3:0] MAX_PAGES_B = 4'(MAX_PAGES);

  // Font memory
  logic [7:0]              font_mem [FONT_BYTES];
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [7:0]              rdata_r;

  // Sequencer
  gpb_pkg::bk_state_t      state_r;
  gpb_pkg::bk_state_t      state_nxt;
  gpb_pkg::cmd_t           cmd_r;
  logic [7:0]              cur_x_r;
  logic [5:0]              cur_y_r;
  logic [4:0]              cols_r;
  logic [2:0]              pages_r;
  logic [4:0]              col_r;
  logic [2:0]              pg_r;
  logic [gpb_pkg::FA_W-1:0] colptr_r;
  logic [9:0]              colbase_r;
  logic [9:0]              pgaddr_r;

  // Read pipeline and output buffer
  logic                    rd_pend_r;
  logic [9:0]              rd_fb_r;
  logic                    rd_last_r;
  logic                    rd_inv_r;
  gpb_pkg::wr_t            ob_r [2];
  logic                    ob_rd_r;
  logic [1:0]              ob_cnt_r;
  logic [1:0]              ob_cnt_nxt;
  logic                    ob_push;
  logic                    ob_pop;
  gpb_pkg::wr_t            ob_in;

  // Width check terms
  logic [7:0]              width;
  logic [8:0]              x_end;
  logic [7:0]              y_end;
  logic                    fits;
  logic [7:0]              cols_a;
  logic [7:0]              cols_b;
  logic [4:0]              cols_w;
  logic [2:0]              pages_w;
  logic [10:0]             page_off;
  logic                    draw_any;
  logic [2:0]              credit;
  logic                    issue;
  logic                    pg_end;
  logic                    col_end;

  // Work out the fit and the clipped extent of the glyph
  assign width    = rdata_r;
  assign x_end    = {1'b0, cur_x_r} + {1'b0, width};
  assign y_end    = {2'b0, cur_y_r} + {2'b0, cfg.glyph_pages, 3'b000};
  assign fits     = (x_end < {1'b0, cfg.display_width}) &&
                    (y_end < {1'b0, cfg.display_height});
  assign cols_a   = (width > {3'b000, cfg.glyph_columns}) ? {3'b000, cfg.glyph_columns} : width;
  assign cols_b   = (cols_a > MAX_COLS_B) ? MAX_COLS_B : cols_a;
  assign cols_w   = cols_b[4:0];
  assign pages_w  = ({1'b0, cfg.glyph_pages} > MAX_PAGES_B) ? MAX_PAGES_B[2:0] : cfg.glyph_pages;
  assign page_off = 11'(cur_y_r[5:3]) * 11'(cfg.display_width);
  assign draw_any = fits && (cols_w != '0) && (pages_w != '0);

  // Issue a read only when the output buffer will have room for it
  assign ob_pop  = out_valid && !out_stall;
  assign credit  = 3'(ob_cnt_r) + 3'(rd_pend_r) - 3'(ob_pop);
  assign pg_end  = (3'(pg_r + 3'd1) == pages_r);
  assign col_end = (5'(col_r + 5'd1) == cols_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpb_pkg::BK_IDLE: begin
        if (!q_stat.empty && !q_cmd.is_load && q_cmd.in_range) begin
          state_nxt = gpb_pkg::BK_WREAD;
        end
      end
      gpb_pkg::BK_WREAD: begin
        state_nxt = gpb_pkg::BK_WCHK;
      end
      gpb_pkg::BK_WCHK: begin
        state_nxt = draw_any ? gpb_pkg::BK_EMIT : gpb_pkg::BK_IDLE;
      end
      gpb_pkg::BK_EMIT: begin
        if (issue && pg_end && col_end) begin
          state_nxt = gpb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = gpb_pkg::BK_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    issue     = 1'b0;
    mem_waddr = q_cmd.addr[AW-1:0];
    mem_raddr = cmd_r.addr[AW-1:0];
    unique case (state_r)
      gpb_pkg::BK_IDLE: begin
        q_pop  = !q_stat.empty;
        mem_we = !q_stat.empty && q_cmd.is_load;
      end
      gpb_pkg::BK_WREAD: begin
        mem_re = 1'b1;
      end
      gpb_pkg::BK_WCHK: begin
      end
      gpb_pkg::BK_EMIT: begin
        issue     = (credit < 3'd2);
        mem_re    = issue;
        mem_raddr = AW'(colptr_r + gpb_pkg::FA_W'(pg_r));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpb_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Font memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[mem_waddr] <= q_cmd.data;
    end
    if (mem_re) begin
      rdata_r <= font_mem[mem_raddr];
    end
  end

  // Cursor: load on an opening item, advance after the width check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else if (state_r == gpb_pkg::BK_IDLE && !q_stat.empty && !q_cmd.is_load &&
                 q_cmd.opens) begin
      cur_x_r <= {1'b0, q_cmd.start_x};
      cur_y_r <= q_cmd.start_y;
    end else if (state_r == gpb_pkg::BK_WCHK) begin
      cur_x_r <= x_end[8] ? 8'hFF : x_end[7:0];
    end
  end

  // Glyph walk: column-major over the clipped extent
  always_ff @(posedge clk) begin
    if (state_r == gpb_pkg::BK_IDLE && !q_stat.empty) begin
      cmd_r <= q_cmd;
    end
    if (state_r == gpb_pkg::BK_WCHK) begin
      cols_r    <= cols_w;
      pages_r   <= pages_w;
      col_r     <= '0;
      pg_r      <= '0;
      colptr_r  <= cmd_r.addr + 1'b1;
      colbase_r <= 10'(page_off + 11'(cur_x_r));
      pgaddr_r  <= 10'(page_off + 11'(cur_x_r));
    end else if (state_r == gpb_pkg::BK_EMIT && issue) begin
      if (pg_end) begin
        pg_r      <= '0;
        col_r     <= 5'(col_r + 5'd1);
        colptr_r  <= colptr_r + gpb_pkg::FA_W'(cfg.glyph_pages);
        colbase_r <= colbase_r + 10'd1;
        pgaddr_r  <= colbase_r + 10'd1;
      end else begin
        pg_r     <= 3'(pg_r + 3'd1);
        pgaddr_r <= pgaddr_r + 10'(cfg.display_width);
      end
    end
  end

  // Carry write metadata alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_fb_r   <= pgaddr_r;
      rd_last_r <= pg_end && col_end;
      rd_inv_r  <= !cmd_r.color;
    end
  end

  // Two-entry output buffer
  assign ob_push         = rd_pend_r;
  assign ob_in.fb_addr   = rd_fb_r;
  assign ob_in.fb_data   = rdata_r ^ {8{rd_inv_r}};
  assign ob_in.last      = rd_last_r;
  assign ob_cnt_nxt      = 2'(ob_cnt_r + 2'(ob_push) - 2'(ob_pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= '0;
      ob_rd_r  <= 1'b0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      if (ob_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_r[ob_rd_r ^ ob_cnt_r[0]] <= ob_in;
    end
  end

  assign out_valid   = (ob_cnt_r != '0);
  assign out_fb_addr = ob_r[ob_rd_r].fb_addr;
  assign out_fb_data = ob_r[ob_rd_r].fb_data;
  assign out_last    = ob_r[ob_rd_r].last;

endmodule

// ===== design/glyph_page_blitter_core.sv =====
// A load item is queued when accepted and written to the font memory once the idle
// back end dequeues it. A draw item passes dequeue, width read and fit check, then
// reads its columns x pages bytes, at most 64, through the single font memory read port.
// Up to 4 queued items may be accepted while the back end is busy drawing.
// Reset (rst_n low, synchronous) clears the cursor, string state and queue and loads
// the default config; the font memory keeps its contents and needs no clearing pass.
// ---------------------------------------------------------------------------
// Glyph page blitter core
// Bitmap font character generator writing page bytes into a framebuffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_page_blitter_core #(
  parameter int FONT_BYTES  = 4096,
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_PAGES   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_byte,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_start_x,
  input  logic [5:0]  in_start_y,
  input  logic        in_opens_string,
  input  logic        in_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_fb_addr,
  output logic [7:0]  out_fb_data,
  output logic        out_last
);

  gpb_pkg::cfg_t    cfg_r;
  logic [7:0]       stride;
  gpb_pkg::q_stat_t q_stat;
  gpb_pkg::cmd_t    push_cmd;
  gpb_pkg::cmd_t    head_cmd;
  logic             q_push;
  logic             q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_width  <= 8'd128;
      cfg_r.display_height <= 7'd64;
      cfg_r.first_char     <= 8'd32;
      cfg_r.last_char      <= 8'd126;
      cfg_r.glyph_columns  <= 5'd8;
      cfg_r.glyph_pages    <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpb_pkg::CFG_DISPLAY_WIDTH:  cfg_r.display_width  <= cfg_wdata;
        gpb_pkg::CFG_DISPLAY_HEIGHT: cfg_r.display_height <= cfg_wdata[6:0];
        gpb_pkg::CFG_FIRST_CHAR:     cfg_r.first_char     <= cfg_wdata;
        gpb_pkg::CFG_LAST_CHAR:      cfg_r.last_char      <= cfg_wdata;
        gpb_pkg::CFG_GLYPH_COLUMNS:  cfg_r.glyph_columns  <= cfg_wdata[4:0];
        gpb_pkg::CFG_GLYPH_PAGES:    cfg_r.glyph_pages    <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // Glyph record stride: one width byte plus the page bytes
  assign stride = 8'(cfg_r.glyph_columns * cfg_r.glyph_pages) + 8'd1;

  gpb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .stride          (stride),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_font_addr    (in_font_addr),
    .in_font_byte    (in_font_byte),
    .in_char_code    (in_char_code),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_opens_string (in_opens_string),
    .in_color        (in_color),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  gpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  gpb_back #(
    .FONT_BYTES  (FONT_BYTES),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_stat      (q_stat),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_fb_addr (out_fb_addr),
    .out_fb_data (out_fb_data),
    .out_last    (out_last)
  );

endmodule

// ===== design/gpb_checker.sv =====
// ---------------------------------------------------------------------------
// Glyph page blitter checker
// Port-level assertions on the blitter core, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glyph_page_blitter_core_macros.svh"

module gpb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [9:0] out_fb_addr,
  input logic [7:0] out_fb_data,
  input logic       out_last
);

  // Hold a stalled write
  `GPB_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled item dropped")
  `GPB_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_fb_addr) && $stable(out_fb_data) && $stable(out_last), "stalled item changed")

  // Come out of reset with no pending writes and an open input
  `GPB_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_valid, "write pending after reset")
  `GPB_ASSERT_RST(a_rst_in, clk, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind glyph_page_blitter_core gpb_checker u_gpb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_fb_addr (out_fb_addr),
  .out_fb_data (out_fb_data),
  .out_last    (out_last)
);
